>>> rtl/core/bfpa_pkg.sv
// Shared types and constants of the best-fit page allocator.
// Used by the table memory and the allocator core; depends on nothing.
package bfpa_pkg;

   localparam int ALLOC_ENTRIES_DEF = 64;
   localparam int HOLE_ENTRIES_DEF  = 64;
   localparam int PAGE_SHIFT_DEF    = 12;

   localparam logic [31:0] HEAP_START_RST = 32'h8000_0000;
   localparam logic [31:0] HEAP_END_RST   = 32'hA000_0000;

   // result status codes
   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_NOSPACE  = 2'd1;
   localparam logic [1:0] ST_FULL     = 2'd2;
   localparam logic [1:0] ST_NOTFOUND = 2'd3;

   // register indexes
   localparam logic CSR_HEAP_START = 1'b0;
   localparam logic CSR_HEAP_END   = 1'b1;

   localparam logic ACT_ALLOC = 1'b0;

   // one row of the allocation table or of the hole table
   typedef struct packed {
      logic        live;
      logic [31:0] pages;
      logic [31:0] start;
   } bfpa_entry_type;

endpackage

>>> rtl/core/bfpa_if.sv
// Request and response channel interfaces of the page allocator.
// Plain valid/ready handshakes; no package dependency.
interface bfpa_req_if;
   logic        valid;
   logic        ready;
   logic        action;
   logic [31:0] size_bytes;
   logic [31:0] address;
   modport source (output valid, action, size_bytes, address, input ready);
   modport sink   (input valid, action, size_bytes, address, output ready);
endinterface

interface bfpa_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [31:0] start_address;
   logic [20:0] page_count;
   modport source (output valid, status, start_address, page_count, input ready);
   modport sink   (input valid, status, start_address, page_count, output ready);
endinterface

>>> rtl/core/bfpa_table.sv
// Synchronous table memory: one write port, one read port, registered read.
// Depends on bfpa_pkg for the entry type.
module bfpa_table #(
   parameter int DEPTH = bfpa_pkg::ALLOC_ENTRIES_DEF,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic                    clock,
   input  logic                    wr_en,
   input  logic [AW-1:0]           wr_addr,
   input  bfpa_pkg::bfpa_entry_type wr_data,
   input  logic [AW-1:0]           rd_addr,
   output bfpa_pkg::bfpa_entry_type rd_data_ff
);
   import bfpa_pkg::*;

   bfpa_entry_type mem [DEPTH];

   // write one row
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read one row, data registered
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

endmodule

>>> rtl/core/best_fit_page_allocator_core.sv
// Best-fit page allocator core.
// Requests arrive on req_bus (action 0 allocate size_bytes, 1 free address);
// one response per request leaves on rsp_bus with status, start address and
// page count. Heap bounds are written on the csr_ port, by the user only while
// idle; the block itself does not enforce this. Allocate scans the hole
// table, free scans the allocation table and then the hole table, one entry
// per cycle through the table read port; the first allocate and an allocate
// on a full allocation table skip the scan.
// One request is in work at a time; req_bus.ready is high in idle, also
// while a finished response still waits in the output register.
// When rsp_bus stalls, the next response waits in its state until the
// output register frees up.
// Reset (synchronous, active high) clears the counts, the started flag and
// restores the heap bounds; table contents are bounded by the counts and
// need no clearing pass.
module best_fit_page_allocator_core #(
   parameter int ALLOC_ENTRIES = bfpa_pkg::ALLOC_ENTRIES_DEF,
   parameter int HOLE_ENTRIES  = bfpa_pkg::HOLE_ENTRIES_DEF,
   parameter int PAGE_SHIFT    = bfpa_pkg::PAGE_SHIFT_DEF
) (
   input  logic          clock,
   input  logic          reset,
   bfpa_req_if.sink      req_bus,
   bfpa_rsp_if.source    rsp_bus,
   input  logic          csr_write_en,
   input  logic [0:0]    csr_index,
   input  logic [31:0]   csr_wdata
);
   import bfpa_pkg::*;

   localparam int AIW = $clog2(ALLOC_ENTRIES);
   localparam int HIW = $clog2(HOLE_ENTRIES);
   localparam int ACW = $clog2(ALLOC_ENTRIES + 1);
   localparam int HCW = $clog2(HOLE_ENTRIES + 1);
   localparam int SW  = (ACW > HCW) ? ACW : HCW;
   localparam int RPW = 33 - PAGE_SHIFT;
   localparam int EW  = 33 + PAGE_SHIFT;
   localparam logic [31:0] PG_MASK = 32'((64'd1 << PAGE_SHIFT) - 64'd1);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_DISP   = 3'd1;
   localparam logic [2:0] S_ASCAN  = 3'd2;
   localparam logic [2:0] S_AUPD   = 3'd3;
   localparam logic [2:0] S_FSCAN  = 3'd4;
   localparam logic [2:0] S_FHSCAN = 3'd5;
   localparam logic [2:0] S_FUPD   = 3'd6;
   localparam logic [2:0] S_DONE   = 3'd7;

   logic [2:0]     state_ff, state_in;
   logic [31:0]    heap_start_ff, heap_start_in;
   logic [31:0]    heap_end_ff, heap_end_in;
   logic           started_ff, started_in;
   logic [31:0]    next_free_ff, next_free_in;
   logic [ACW-1:0] alloc_count_ff, alloc_count_in;
   logic [HCW-1:0] hole_count_ff, hole_count_in;
   logic           act_ff, act_in;
   logic [RPW-1:0] rpages_ff, rpages_in;
   logic [31:0]    addr_ff, addr_in;
   logic [SW-1:0]  scan_ff, scan_in;
   logic           pend_ff, pend_in;
   logic [SW-1:0]  pend_idx_ff, pend_idx_in;
   logic           found_ff, found_in;
   logic [SW-1:0]  best_idx_ff, best_idx_in;
   logic [31:0]    best_pages_ff, best_pages_in;
   logic [31:0]    best_start_ff, best_start_in;
   logic           hole_hit_ff, hole_hit_in;
   logic [SW-1:0]  fa_idx_ff, fa_idx_in;
   logic [31:0]    fa_pages_ff, fa_pages_in;
   logic [1:0]     res_status_ff, res_status_in;
   logic [31:0]    res_addr_ff, res_addr_in;
   logic [20:0]    res_pages_ff, res_pages_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic [1:0]     rsp_status_ff, rsp_status_in;
   logic [31:0]    rsp_addr_ff, rsp_addr_in;
   logic [20:0]    rsp_pages_ff, rsp_pages_in;

   logic           a_wr_en, h_wr_en;
   logic [AIW-1:0] a_wr_addr, a_rd_addr;
   logic [HIW-1:0] h_wr_addr, h_rd_addr;
   bfpa_entry_type a_wr_data, h_wr_data, a_rd, h_rd;

   logic [32:0]    req_sum;
   logic [32:0]    bytes33;
   logic [31:0]    rpages32;
   logic [31:0]    space;
   logic [31:0]    heap_pg;
   logic [SW-1:0]  scan_cnt;
   logic           issue;
   logic           scan_done;
   logic [EW-1:0]  hole_end;
   logic           req_fire;

   bfpa_table #(.DEPTH(ALLOC_ENTRIES), .AW(AIW)) u_alloc_tab (
      .clock(clock), .wr_en(a_wr_en), .wr_addr(a_wr_addr), .wr_data(a_wr_data),
      .rd_addr(a_rd_addr), .rd_data_ff(a_rd)
   );

   bfpa_table #(.DEPTH(HOLE_ENTRIES), .AW(HIW)) u_hole_tab (
      .clock(clock), .wr_en(h_wr_en), .wr_addr(h_wr_addr), .wr_data(h_wr_data),
      .rd_addr(h_rd_addr), .rd_data_ff(h_rd)
   );

   assign req_bus.ready        = (state_ff == S_IDLE);
   assign req_fire             = req_bus.valid && req_bus.ready;
   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.status       = rsp_status_ff;
   assign rsp_bus.start_address = rsp_addr_ff;
   assign rsp_bus.page_count   = rsp_pages_ff;

   // round the request size up to pages
   assign req_sum  = 33'(req_bus.size_bytes) + 33'(PG_MASK);
   assign bytes33  = 33'(rpages_ff) << PAGE_SHIFT;
   assign rpages32 = 32'(rpages_ff);
   assign space    = (heap_end_ff > next_free_ff) ? (heap_end_ff - next_free_ff) : 32'd0;
   assign heap_pg  = space >> PAGE_SHIFT;

   // scan sequencing: one table read issued per cycle
   assign scan_cnt  = (state_ff == S_FSCAN) ? SW'(alloc_count_ff) : SW'(hole_count_ff);
   assign issue     = (scan_ff < scan_cnt);
   assign scan_done = !issue && !pend_ff;
   assign a_rd_addr = scan_ff[AIW-1:0];
   assign h_rd_addr = scan_ff[HIW-1:0];
   assign hole_end  = EW'(h_rd.start) + (EW'(h_rd.pages) << PAGE_SHIFT);

   // next state, table writes and results
   always_comb begin
      state_in       = state_ff;
      heap_start_in  = heap_start_ff;
      heap_end_in    = heap_end_ff;
      started_in     = started_ff;
      next_free_in   = next_free_ff;
      alloc_count_in = alloc_count_ff;
      hole_count_in  = hole_count_ff;
      act_in         = act_ff;
      rpages_in      = rpages_ff;
      addr_in        = addr_ff;
      scan_in        = scan_ff;
      pend_in        = 1'b0;
      pend_idx_in    = scan_ff;
      found_in       = found_ff;
      best_idx_in    = best_idx_ff;
      best_pages_in  = best_pages_ff;
      best_start_in  = best_start_ff;
      hole_hit_in    = hole_hit_ff;
      fa_idx_in      = fa_idx_ff;
      fa_pages_in    = fa_pages_ff;
      res_status_in  = res_status_ff;
      res_addr_in    = res_addr_ff;
      res_pages_in   = res_pages_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_bus.ready;
      rsp_status_in  = rsp_status_ff;
      rsp_addr_in    = rsp_addr_ff;
      rsp_pages_in   = rsp_pages_ff;
      a_wr_en        = 1'b0;
      a_wr_addr      = alloc_count_ff[AIW-1:0];
      a_wr_data      = '0;
      h_wr_en        = 1'b0;
      h_wr_addr      = best_idx_ff[HIW-1:0];
      h_wr_data      = '0;

      // configuration writes
      if (csr_write_en) begin
         unique case (csr_index[0])
            CSR_HEAP_START: begin
               heap_start_in = csr_wdata;
               if (!started_ff) begin
                  next_free_in = csr_wdata;
               end
            end
            default: heap_end_in = csr_wdata;
         endcase
      end

      // advance scan pipeline
      if (state_ff == S_ASCAN || state_ff == S_FSCAN || state_ff == S_FHSCAN) begin
         if (issue) begin
            scan_in = scan_ff + SW'(1);
            pend_in = 1'b1;
         end
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               act_in    = req_bus.action;
               rpages_in = req_sum[32:PAGE_SHIFT];
               addr_in   = req_bus.address & ~PG_MASK;
               state_in  = S_DISP;
            end
         end
         S_DISP: begin
            scan_in     = '0;
            found_in    = 1'b0;
            hole_hit_in = 1'b0;
            if (act_ff == ACT_ALLOC) begin
               if (alloc_count_ff >= ACW'(ALLOC_ENTRIES)) begin
                  res_status_in = ST_FULL;
                  res_addr_in   = '0;
                  res_pages_in  = '0;
                  state_in      = S_DONE;
               end else if (!started_ff) begin
                  state_in = S_DONE;
                  if (bytes33 > {1'b0, space}) begin
                     res_status_in = ST_NOSPACE;
                     res_addr_in   = '0;
                     res_pages_in  = '0;
                  end else begin
                     // carve from heap start, rest becomes the first hole
                     a_wr_en        = 1'b1;
                     a_wr_data      = '{live: 1'b1, pages: rpages32, start: next_free_ff};
                     alloc_count_in = alloc_count_ff + ACW'(1);
                     next_free_in   = next_free_ff + bytes33[31:0];
                     h_wr_en        = 1'b1;
                     h_wr_addr      = '0;
                     h_wr_data      = '{live: 1'b1,
                                        pages: (heap_pg >= rpages32) ?
                                               (heap_pg - rpages32) : 32'd0,
                                        start: next_free_ff + bytes33[31:0]};
                     hole_count_in  = HCW'(1);
                     started_in     = 1'b1;
                     res_status_in  = ST_OK;
                     res_addr_in    = next_free_ff;
                     res_pages_in   = rpages32[20:0];
                  end
               end else begin
                  state_in = S_ASCAN;
               end
            end else begin
               state_in = S_FSCAN;
            end
         end
         S_ASCAN: begin
            // keep the smallest fitting hole, earliest on ties
            if (pend_ff && h_rd.live && h_rd.pages >= rpages32 &&
                (!found_ff || h_rd.pages < best_pages_ff)) begin
               found_in      = 1'b1;
               best_idx_in   = pend_idx_ff;
               best_pages_in = h_rd.pages;
               best_start_in = h_rd.start;
            end
            if (scan_done) begin
               if (!found_ff) begin
                  res_status_in = ST_NOSPACE;
                  res_addr_in   = '0;
                  res_pages_in  = '0;
                  state_in      = S_DONE;
               end else begin
                  state_in = S_AUPD;
               end
            end
         end
         S_AUPD: begin
            // record the allocation, shrink or retire the hole
            a_wr_en        = 1'b1;
            a_wr_data      = '{live: 1'b1, pages: rpages32, start: best_start_ff};
            alloc_count_in = alloc_count_ff + ACW'(1);
            h_wr_en        = 1'b1;
            if (best_pages_ff == rpages32) begin
               h_wr_data = '0;
            end else begin
               h_wr_data = '{live: 1'b1, pages: best_pages_ff - rpages32,
                             start: best_start_ff + bytes33[31:0]};
            end
            res_status_in = ST_OK;
            res_addr_in   = best_start_ff;
            res_pages_in  = rpages32[20:0];
            state_in      = S_DONE;
         end
         S_FSCAN: begin
            // find the earliest live allocation at the address
            if (pend_ff && !found_ff && a_rd.live && a_rd.start == addr_ff) begin
               found_in    = 1'b1;
               fa_idx_in   = pend_idx_ff;
               fa_pages_in = a_rd.pages;
            end
            if (scan_done) begin
               if (!found_ff) begin
                  res_status_in = ST_NOTFOUND;
                  res_addr_in   = '0;
                  res_pages_in  = '0;
                  state_in      = S_DONE;
               end else begin
                  scan_in  = '0;
                  state_in = S_FHSCAN;
               end
            end
         end
         S_FHSCAN: begin
            // find the earliest live hole ending at the address
            if (pend_ff && !hole_hit_ff && h_rd.live && hole_end == EW'(addr_ff)) begin
               hole_hit_in   = 1'b1;
               best_idx_in   = pend_idx_ff;
               best_pages_in = h_rd.pages;
               best_start_in = h_rd.start;
            end
            if (scan_done) begin
               state_in = S_FUPD;
            end
         end
         S_FUPD: begin
            state_in = S_DONE;
            if (!hole_hit_ff && hole_count_ff >= HCW'(HOLE_ENTRIES)) begin
               res_status_in = ST_FULL;
               res_addr_in   = '0;
               res_pages_in  = '0;
            end else begin
               h_wr_en = 1'b1;
               if (hole_hit_ff) begin
                  h_wr_data = '{live: 1'b1, pages: best_pages_ff + fa_pages_ff,
                                start: best_start_ff};
               end else begin
                  h_wr_addr     = hole_count_ff[HIW-1:0];
                  h_wr_data     = '{live: 1'b1, pages: fa_pages_ff, start: addr_ff};
                  hole_count_in = hole_count_ff + HCW'(1);
               end
               a_wr_en       = 1'b1;
               a_wr_addr     = fa_idx_ff[AIW-1:0];
               a_wr_data     = '0;
               res_status_in = ST_OK;
               res_addr_in   = addr_ff;
               res_pages_in  = fa_pages_ff[20:0];
            end
         end
         default: begin
            // hand the result to the output register once it is free
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_addr_in   = res_addr_ff;
               rsp_pages_in  = res_pages_ff;
               state_in      = S_IDLE;
            end
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         heap_start_ff  <= HEAP_START_RST;
         heap_end_ff    <= HEAP_END_RST;
         started_ff     <= 1'b0;
         next_free_ff   <= HEAP_START_RST;
         alloc_count_ff <= '0;
         hole_count_ff  <= '0;
         pend_ff        <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         heap_start_ff  <= heap_start_in;
         heap_end_ff    <= heap_end_in;
         started_ff     <= started_in;
         next_free_ff   <= next_free_in;
         alloc_count_ff <= alloc_count_in;
         hole_count_ff  <= hole_count_in;
         pend_ff        <= pend_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      act_ff        <= act_in;
      rpages_ff     <= rpages_in;
      addr_ff       <= addr_in;
      scan_ff       <= scan_in;
      pend_idx_ff   <= pend_idx_in;
      found_ff      <= found_in;
      best_idx_ff   <= best_idx_in;
      best_pages_ff <= best_pages_in;
      best_start_ff <= best_start_in;
      hole_hit_ff   <= hole_hit_in;
      fa_idx_ff     <= fa_idx_in;
      fa_pages_ff   <= fa_pages_in;
      res_status_ff <= res_status_in;
      res_addr_ff   <= res_addr_in;
      res_pages_ff  <= res_pages_in;
      rsp_status_ff <= rsp_status_in;
      rsp_addr_ff   <= rsp_addr_in;
      rsp_pages_ff  <= rsp_pages_in;
   end

endmodule

>>> tb/tb_best_fit_page_allocator_core.sv
// Testbench of the best-fit page allocator core: directed and random requests
// checked against a cycle-free model of the allocation and hole tables.
// Depends on bfpa_pkg, bfpa_if.sv and best_fit_page_allocator_core.
`timescale 1ns / 100ps

module tb_best_fit_page_allocator_core;
   import bfpa_pkg::*;

   localparam int NUM_ALLOCS = 64;
   localparam int NUM_HOLES  = 64;
   localparam int PG_SHIFT   = 12;
   localparam logic ACT_FREE = 1'b1;

   typedef struct {
      logic [1:0]  status;
      logic [31:0] start;
      logic [20:0] pages;
   } alloc_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_write_en = 1'b0;
   logic [0:0] csr_index = '0;
   logic [31:0] csr_wdata = '0;

   bfpa_req_if req_if ();
   bfpa_rsp_if rsp_if ();

   best_fit_page_allocator_core dut (
      .clock        (clock),
      .reset        (reset),
      .req_bus      (req_if.sink),
      .rsp_bus      (rsp_if.source),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // heap model
   logic [31:0] heap_lo, heap_hi, carve_ptr;
   logic        heap_started;
   int          n_allocs, n_holes;
   logic [31:0] a_start [NUM_ALLOCS];
   logic [31:0] a_pages [NUM_ALLOCS];
   logic        a_live  [NUM_ALLOCS];
   logic [31:0] h_start [NUM_HOLES];
   logic [31:0] h_pages [NUM_HOLES];
   logic        h_live  [NUM_HOLES];

   alloc_result_type pending_results[$];
   int errors = 0, results_seen = 0, requests_sent = 0;
   int ok_allocs = 0, ok_frees = 0, full_hits = 0;
   bit calm = 1'b0;

   function automatic alloc_result_type heap_step(logic act, logic [31:0] size,
                                                  logic [31:0] addr_in);
      alloc_result_type r;
      logic [32:0] pg33, space;
      logic [31:0] pg, heap_pg, addr;
      logic [33:0] nbytes;
      logic [63:0] hole_end;
      int best, i, k;
      r = '{ST_OK, 32'd0, 21'd0};
      if (act == ACT_ALLOC) begin
         pg33   = ({1'b0, size} + 33'd4095) >> PG_SHIFT;
         pg     = pg33[31:0];
         nbytes = {1'b0, pg33} << PG_SHIFT;
         if (n_allocs >= NUM_ALLOCS) begin
            r.status = ST_FULL;
            return r;
         end
         if (!heap_started) begin
            space   = (heap_hi > carve_ptr) ? {1'b0, heap_hi - carve_ptr} : 33'd0;
            heap_pg = 32'(space[32:PG_SHIFT]);
            if (nbytes > {1'b0, space}) begin
               r.status = ST_NOSPACE;
               return r;
            end
            addr = carve_ptr;
            a_start[n_allocs] = addr; a_pages[n_allocs] = pg; a_live[n_allocs] = 1'b1;
            n_allocs++;
            carve_ptr  = carve_ptr + nbytes[31:0];
            h_start[0] = carve_ptr;
            h_pages[0] = (heap_pg >= pg) ? heap_pg - pg : 32'd0;
            h_live[0]  = 1'b1;
            n_holes    = 1;
            heap_started = 1'b1;
            r.start = addr; r.pages = pg[20:0];
            ok_allocs++;
            return r;
         end
         // smallest valid hole that fits, earliest on ties
         best = -1;
         for (i = 0; i < n_holes; i++)
            if (h_live[i] && h_pages[i] >= pg && (best < 0 || h_pages[i] < h_pages[best]))
               best = i;
         if (best < 0) begin
            r.status = ST_NOSPACE;
            return r;
         end
         addr = h_start[best];
         a_start[n_allocs] = addr; a_pages[n_allocs] = pg; a_live[n_allocs] = 1'b1;
         n_allocs++;
         if (h_pages[best] == pg) begin
            h_live[best] = 1'b0; h_pages[best] = '0; h_start[best] = '0;
         end else begin
            h_pages[best] = h_pages[best] - pg;
            h_start[best] = h_start[best] + nbytes[31:0];
         end
         r.start = addr; r.pages = pg[20:0];
         ok_allocs++;
         return r;
      end
      // free: earliest live allocation at the page address
      addr = {addr_in[31:PG_SHIFT], {PG_SHIFT{1'b0}}};
      for (i = 0; i < n_allocs; i++)
         if (a_live[i] && a_start[i] == addr) break;
      if (i >= n_allocs) begin
         r.status = ST_NOTFOUND;
         return r;
      end
      pg = a_pages[i];
      for (k = 0; k < n_holes; k++) begin
         hole_end = {32'd0, h_start[k]} + ({32'd0, h_pages[k]} << PG_SHIFT);
         if (h_live[k] && hole_end == {32'd0, addr}) break;
      end
      if (k < n_holes) begin
         h_pages[k] = h_pages[k] + pg;
      end else begin
         if (n_holes >= NUM_HOLES) begin
            r.status = ST_FULL;
            full_hits++;
            return r;
         end
         h_start[n_holes] = addr; h_pages[n_holes] = pg; h_live[n_holes] = 1'b1;
         n_holes++;
      end
      a_live[i] = 1'b0; a_start[i] = '0; a_pages[i] = '0;
      r.start = addr; r.pages = pg[20:0];
      ok_frees++;
      return r;
   endfunction

   // drive one request, hold it until accepted, then queue its result
   task automatic send_request(logic act, logic [31:0] size, logic [31:0] addr);
      @(negedge clock);
      while (!calm && $urandom_range(99) < 9) begin
         req_if.valid = 1'b0;
         @(negedge clock);
      end
      req_if.valid      = 1'b1;
      req_if.action     = act;
      req_if.size_bytes = size;
      req_if.address    = addr;
      do @(posedge clock); while (!req_if.ready);
      pending_results.push_back(heap_step(act, size, addr));
      requests_sent++;
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_if.valid = 1'b0;
      wait (pending_results.size() == 0);
      repeat (10) @(negedge clock);
   endtask

   // write one heap bound while idle and mirror it in the model
   task automatic write_csr(logic idx, logic [31:0] data);
      wait_drained();
      csr_write_en = 1'b1;
      csr_index    = idx;
      csr_wdata    = data;
      @(negedge clock);
      csr_write_en = 1'b0;
      if (idx == CSR_HEAP_START) begin
         heap_lo = data;
         if (!heap_started) carve_ptr = data;
      end else begin
         heap_hi = data;
      end
   endtask

   // compare each response with the oldest outstanding expectation
   always @(posedge clock) begin
      alloc_result_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         results_seen++;
         if (pending_results.size() == 0) begin
            errors++;
            if (errors <= 10) $display("ERROR: response with no request outstanding");
         end else begin
            want = pending_results.pop_front();
            if (rsp_if.status !== want.status || rsp_if.start_address !== want.start ||
                rsp_if.page_count !== want.pages) begin
               errors++;
               if (errors <= 10)
                  $display("ERROR: status %0d/%0d start %h/%h pages %0d/%0d (exp/act)",
                           want.status, rsp_if.status, want.start, rsp_if.start_address,
                           want.pages, rsp_if.page_count);
            end
         end
      end
   end

   // random response stalls
   always @(negedge clock)
      rsp_if.ready <= calm || ($urandom_range(99) >= 9);

   // failing bounds before the heap is started
   task automatic test_early_bounds();
      write_csr(CSR_HEAP_START, 32'hFFFF_F000);
      write_csr(CSR_HEAP_END, 32'hFFFF_FFFF);
      send_request(ACT_ALLOC, 32'd1, 32'd0);
      send_request(ACT_FREE, 32'd0, 32'hFFFF_FFFF);
      write_csr(CSR_HEAP_START, 32'h1000_0000);
      write_csr(CSR_HEAP_END, 32'h0000_0000);
      send_request(ACT_ALLOC, 32'd4096, 32'd0);
      write_csr(CSR_HEAP_START, 32'h0000_0000);
      send_request(ACT_ALLOC, 32'hFFFF_FFFF, 32'd0);
      write_csr(CSR_HEAP_END, 32'h0010_0000);
   endtask

   // zero-page start, shared addresses, rounding and late register writes
   task automatic test_directed();
      send_request(ACT_ALLOC, 32'd0, 32'd0);
      send_request(ACT_ALLOC, 32'd1, 32'd0);
      send_request(ACT_ALLOC, 32'd4096, 32'd0);
      send_request(ACT_ALLOC, 32'd4097, 32'd0);
      send_request(ACT_ALLOC, 32'hFFFF_FFFF, 32'd0);
      send_request(ACT_FREE, 32'd0, 32'h0000_0FFF);
      send_request(ACT_FREE, 32'd0, 32'h0000_0000);
      send_request(ACT_FREE, 32'd0, 32'h0000_2ABC);
      send_request(ACT_FREE, 32'd0, 32'hFFFF_FFFF);
      send_request(ACT_ALLOC, 32'd8192, 32'd0);
      send_request(ACT_ALLOC, 32'd4096, 32'd0);
      send_request(ACT_FREE, 32'd0, 32'h0000_1000);
      write_csr(CSR_HEAP_START, 32'hFFFF_FFFF);
      write_csr(CSR_HEAP_END, 32'h0000_0000);
      send_request(ACT_ALLOC, 32'd12288, 32'd0);
      send_request(ACT_ALLOC, 32'h000F_F000, 32'd0);
   endtask

   // mostly frees of live ranges and small allocations, some noise
   task automatic test_random(int count);
      logic [31:0] size, addr;
      int pick, j;
      for (int n = 0; n < count; n++) begin
         calm = (n >= count / 3 && n < count / 3 + 200);
         if (n == count / 2) wait_drained();
         pick = $urandom_range(99);
         if (pick < 45) begin
            size = (pick < 5) ? $urandom() : $urandom_range(8 * 4096);
            send_request(ACT_ALLOC, size, $urandom());
         end else begin
            addr = $urandom();
            if (pick < 90 && n_allocs > 0) begin
               j = $urandom_range(n_allocs - 1);
               if (a_live[j]) addr = a_start[j] | $urandom_range(4095);
            end
            send_request(ACT_FREE, $urandom(), addr);
         end
      end
      calm = 1'b0;
   endtask

   initial begin
      req_if.valid = 1'b0;
      req_if.action = ACT_ALLOC;
      req_if.size_bytes = '0;
      req_if.address = '0;
      rsp_if.ready = 1'b0;
      heap_lo = HEAP_START_RST;
      heap_hi = HEAP_END_RST;
      carve_ptr = HEAP_START_RST;
      heap_started = 1'b0;
      n_allocs = 0;
      n_holes = 0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_early_bounds();
      test_directed();
      test_random(1500);
      wait_drained();
      repeat (200) @(negedge clock);

      $display("Sent %0d requests, checked %0d responses: %0d allocations and %0d frees ok,",
               requests_sent, results_seen, ok_allocs, ok_frees);
      $display("%0d frees hit a full hole table, %0d mismatches", full_hits, errors);
      if (errors == 0 && pending_results.size() == 0)
         $display("tb_best_fit_page_allocator_core passed");
      else
         $display("tb_best_fit_page_allocator_core failed");
      $finish;
   end

   initial begin
      #20ms;
      $display("tb_best_fit_page_allocator_core failed");
      $finish;
   end

endmodule
